### hw/rtl/lti_pkg.sv
// Shared constants, types and the tetrahedron corner table of the 3D LUT interpolator.
// Depends on nothing; imported by every module of the block except lti_ram.
`timescale 1ns / 1ps
`default_nettype none

package lti_pkg;

  localparam int GRID_MAX   = 33;
  localparam int COLOR_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int CELLS   = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int AW      = $clog2(CELLS);
  localparam int GW      = $clog2(GRID_MAX + 1);
  localparam int CFG_W   = 6;
  localparam int IDX_W   = 16;
  localparam int COORD_W = FRAC_BITS + 1;
  localparam int PROD_W  = COORD_W + GW;
  localparam int T1_W    = $clog2(GRID_MAX * GRID_MAX);
  localparam int DIFF_W  = COLOR_BITS + 1;
  localparam int MUL_W   = DIFF_W + FRAC_BITS + 1;
  localparam int ACC_W   = COLOR_BITS + FRAC_BITS + 4;
  localparam int NCORN   = 8;

  localparam logic [CFG_W-1:0]        GRID_RESET = CFG_W'(GRID_MAX);
  localparam logic [COORD_W-1:0]      ONE_FX     = COORD_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] HALF_FX    = ACC_W'(1 << (FRAC_BITS - 1));

  typedef logic [COLOR_BITS-1:0] color_t;
  typedef color_t [2:0]          rgb_t;     // [0] red, [1] green, [2] blue
  typedef logic [AW-1:0]         addr_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;

  // Tetrahedra in the order in which ties are resolved.
  typedef enum logic [2:0] {
    TET_XYZ, TET_XZY, TET_ZXY, TET_YXZ, TET_YZX, TET_ZYX
  } tetra_e;

  typedef struct packed {
    logic                 op;
    logic [IDX_W-1:0]     idx;
    rgb_t                 color;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [COORD_W-1:0]   cz;
  } req_t;

  typedef struct packed {
    logic   valid;
    logic   pix;
    tetra_e tetra;
    frac_t  fx;
    frac_t  fy;
    frac_t  fz;
  } side_t;

  // Corner pairs (plus, minus) for the x, y and z weights, most significant first.
  // Corner number is {xi, yi, zi} with 1 meaning the upper grid point.
  function automatic logic [17:0] tetra_pairs(tetra_e t);
    logic [17:0] p;
    case (t)
      TET_XYZ: p = {3'd4, 3'd0, 3'd6, 3'd4, 3'd7, 3'd6};
      TET_XZY: p = {3'd4, 3'd0, 3'd7, 3'd5, 3'd5, 3'd4};
      TET_ZXY: p = {3'd5, 3'd1, 3'd7, 3'd5, 3'd1, 3'd0};
      TET_YXZ: p = {3'd6, 3'd2, 3'd2, 3'd0, 3'd7, 3'd6};
      TET_YZX: p = {3'd7, 3'd3, 3'd2, 3'd0, 3'd3, 3'd2};
      TET_ZYX: p = {3'd7, 3'd3, 3'd3, 3'd1, 3'd1, 3'd0};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lti_ram.sv
// Generic single-address RAM with a registered read port.
// Stand-alone; used for the color table copies.
`timescale 1ns / 1ps
`default_nettype none

module lti_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48,
  parameter int AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/lti_addr.sv
// Front of the pipeline: coordinate scaling, cell corners, tetrahedron choice, the
// eight corner addresses and the table write port. Depends on lti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lti_addr (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic [lti_pkg::CFG_W-1:0] grid_i,
  input  wire logic                      in_valid_i,
  input  wire lti_pkg::req_t             req_i,
  output lti_pkg::side_t                 side_o,
  output lti_pkg::addr_t                 addr_o [lti_pkg::NCORN],
  output logic                           we_o,
  output lti_pkg::rgb_t                  wdata_o
);
  import lti_pkg::*;

  logic [GW-1:0] n, nm1;

  always_comb begin
    if (grid_i < CFG_W'(2)) begin
      n = GW'(2);
    end else if (32'(grid_i) > GRID_MAX) begin
      n = GW'(GRID_MAX);
    end else begin
      n = GW'(grid_i);
    end
    nm1 = n - GW'(1);
  end

  // Stage A: scale by n-1, split into base index and fraction.
  logic [COORD_W-1:0] coord [3];
  logic [COORD_W-1:0] sat [3];
  logic [PROD_W-1:0]  prod [3];
  logic [GW-1:0]      a_lo_d [3];
  frac_t              a_fr_d [3];

  always_comb begin
    coord[0] = req_i.cx;
    coord[1] = req_i.cy;
    coord[2] = req_i.cz;
    for (int k = 0; k < 3; k++) begin
      sat[k]    = (coord[k] > ONE_FX) ? ONE_FX : coord[k];
      prod[k]   = PROD_W'(sat[k]) * PROD_W'(nm1);
      a_lo_d[k] = prod[k][FRAC_BITS +: GW];
      a_fr_d[k] = prod[k][FRAC_BITS-1:0];
    end
  end

  logic          a_valid_q, a_op_q, a_wr_q;
  addr_t         a_idx_q;
  rgb_t          a_color_q;
  logic [GW-1:0] a_lo_q [3];
  frac_t         a_fr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_op_q    <= req_i.op;
      a_wr_q    <= (32'(req_i.idx) < CELLS);
      a_idx_q   <= addr_t'(req_i.idx);
      a_color_q <= req_i.color;
      a_lo_q    <= a_lo_d;
      a_fr_q    <= a_fr_d;
    end
  end

  // Stage B: upper corner held at the top of the grid, tetrahedron choice.
  logic [GW-1:0] b_hi_d [3];
  tetra_e        b_tetra_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      b_hi_d[k] = (a_lo_q[k] == nm1) ? a_lo_q[k] : a_lo_q[k] + GW'(1);
    end
    if (a_fr_q[0] >= a_fr_q[1] && a_fr_q[1] >= a_fr_q[2]) begin
      b_tetra_d = TET_XYZ;
    end else if (a_fr_q[0] >= a_fr_q[2] && a_fr_q[2] >= a_fr_q[1]) begin
      b_tetra_d = TET_XZY;
    end else if (a_fr_q[2] >= a_fr_q[0] && a_fr_q[0] >= a_fr_q[1]) begin
      b_tetra_d = TET_ZXY;
    end else if (a_fr_q[1] >= a_fr_q[0] && a_fr_q[0] >= a_fr_q[2]) begin
      b_tetra_d = TET_YXZ;
    end else if (a_fr_q[1] >= a_fr_q[2] && a_fr_q[2] >= a_fr_q[0]) begin
      b_tetra_d = TET_YZX;
    end else begin
      b_tetra_d = TET_ZYX;
    end
  end

  logic          b_valid_q, b_op_q, b_wr_q;
  addr_t         b_idx_q;
  rgb_t          b_color_q;
  logic [GW-1:0] b_lo_q [3];
  logic [GW-1:0] b_hi_q [3];
  frac_t         b_fr_q [3];
  tetra_e        b_tetra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_op_q    <= a_op_q;
      b_wr_q    <= a_wr_q;
      b_idx_q   <= a_idx_q;
      b_color_q <= a_color_q;
      b_lo_q    <= a_lo_q;
      b_hi_q    <= b_hi_d;
      b_fr_q    <= a_fr_q;
      b_tetra_q <= b_tetra_d;
    end
  end

  // Stage C: row offsets xi*n+yi for the four (x, y) corner pairs.
  logic [T1_W-1:0] c_t1_d [4];
  logic [GW-1:0]   xi, yi;
  logic [2*GW-1:0] row;

  always_comb begin
    xi  = '0;
    yi  = '0;
    row = '0;
    for (int j = 0; j < 4; j++) begin
      xi        = j[1] ? b_hi_q[0] : b_lo_q[0];
      yi        = j[0] ? b_hi_q[1] : b_lo_q[1];
      row       = (2*GW)'(xi) * (2*GW)'(n) + (2*GW)'(yi);
      c_t1_d[j] = T1_W'(row);
    end
  end

  logic            c_valid_q, c_op_q, c_wr_q;
  addr_t           c_idx_q;
  rgb_t            c_color_q;
  logic [T1_W-1:0] c_t1_q [4];
  logic [GW-1:0]   c_zlo_q, c_zhi_q;
  frac_t           c_fr_q [3];
  tetra_e          c_tetra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_op_q    <= b_op_q;
      c_wr_q    <= b_wr_q;
      c_idx_q   <= b_idx_q;
      c_color_q <= b_color_q;
      c_t1_q    <= c_t1_d;
      c_zlo_q   <= b_lo_q[2];
      c_zhi_q   <= b_hi_q[2];
      c_fr_q    <= b_fr_q;
      c_tetra_q <= b_tetra_q;
    end
  end

  // Stage D: full corner addresses; a table write drives its own index to every copy.
  addr_t                 d_addr_d [NCORN];
  logic [T1_W+GW-1:0]    lin;

  always_comb begin
    lin = '0;
    for (int k = 0; k < NCORN; k++) begin
      lin = (T1_W+GW)'(c_t1_q[k/2]) * (T1_W+GW)'(n)
          + (T1_W+GW)'(k[0] ? c_zhi_q : c_zlo_q);
      d_addr_d[k] = c_op_q ? addr_t'(lin) : c_idx_q;
    end
  end

  logic   d_valid_q, d_op_q, d_we_q;
  addr_t  d_addr_q [NCORN];
  rgb_t   d_color_q;
  frac_t  d_fr_q [3];
  tetra_e d_tetra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      d_we_q    <= 1'b0;
    end else if (en_i) begin
      d_valid_q <= c_valid_q;
      d_we_q    <= c_valid_q && !c_op_q && c_wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_op_q    <= c_op_q;
      d_addr_q  <= d_addr_d;
      d_color_q <= c_color_q;
      d_fr_q    <= c_fr_q;
      d_tetra_q <= c_tetra_q;
    end
  end

  assign side_o.valid = d_valid_q;
  assign side_o.pix   = d_op_q;
  assign side_o.tetra = d_tetra_q;
  assign side_o.fx    = d_fr_q[0];
  assign side_o.fy    = d_fr_q[1];
  assign side_o.fz    = d_fr_q[2];
  assign addr_o       = d_addr_q;
  assign we_o         = d_we_q;
  assign wdata_o      = d_color_q;

endmodule

`default_nettype wire

### hw/rtl/lti_blend.sv
// Back of the pipeline: corner differences, fraction weighting, sum, rounding and
// clamping, and the output register. Depends on lti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lti_blend (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire lti_pkg::side_t side_i,
  input  wire lti_pkg::rgb_t  corner_i [lti_pkg::NCORN],
  output logic                out_valid_o,
  output lti_pkg::rgb_t       out_rgb_o
);
  import lti_pkg::*;

  // Side data is registered to line up with the registered table reads.
  logic   s_valid_q;
  tetra_e s_tetra_q;
  frac_t  s_fr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (en_i) begin
      s_valid_q <= side_i.valid && side_i.pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_tetra_q <= side_i.tetra;
      s_fr_q[0] <= side_i.fx;
      s_fr_q[1] <= side_i.fy;
      s_fr_q[2] <= side_i.fz;
    end
  end

  // Stage E: the three corner differences of the chosen tetrahedron.
  logic [17:0]               pairs;
  logic [2:0]                cp, cm;
  logic signed [DIFF_W-1:0]  e_d_d [3][3];

  always_comb begin
    pairs = tetra_pairs(s_tetra_q);
    cp    = '0;
    cm    = '0;
    for (int j = 0; j < 3; j++) begin
      cp = pairs[17 - 6*j -: 3];
      cm = pairs[14 - 6*j -: 3];
      for (int ch = 0; ch < 3; ch++) begin
        e_d_d[j][ch] = $signed({1'b0, corner_i[cp][ch]})
                     - $signed({1'b0, corner_i[cm][ch]});
      end
    end
  end

  logic                      e_valid_q;
  logic signed [DIFF_W-1:0]  e_d_q [3][3];
  rgb_t                      e_base_q;
  frac_t                     e_fr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en_i) begin
      e_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_d_q    <= e_d_d;
      e_base_q <= corner_i[0];
      e_fr_q   <= s_fr_q;
    end
  end

  // Stage F: weight each difference by its fraction.
  logic signed [MUL_W-1:0] f_m_d [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int ch = 0; ch < 3; ch++) begin
        f_m_d[j][ch] = MUL_W'(e_d_q[j][ch]) * MUL_W'($signed({1'b0, e_fr_q[j]}));
      end
    end
  end

  logic                    f_valid_q;
  logic signed [MUL_W-1:0] f_m_q [3][3];
  rgb_t                    f_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_m_q    <= f_m_d;
      f_base_q <= e_base_q;
    end
  end

  // Stage G: two partial sums, the rounding half folded into the first.
  logic signed [ACC_W-1:0] g_s1_d [3];
  logic signed [ACC_W-1:0] g_s2_d [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      g_s1_d[ch] = ACC_W'($signed({1'b0, f_base_q[ch], {FRAC_BITS{1'b0}}}))
                 + ACC_W'(f_m_q[0][ch]) + HALF_FX;
      g_s2_d[ch] = ACC_W'(f_m_q[1][ch]) + ACC_W'(f_m_q[2][ch]);
    end
  end

  logic                    g_valid_q;
  logic signed [ACC_W-1:0] g_s1_q [3];
  logic signed [ACC_W-1:0] g_s2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (en_i) begin
      g_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_s1_q <= g_s1_d;
      g_s2_q <= g_s2_d;
    end
  end

  // Stage H: final sum, drop the fraction, clamp into the color range.
  logic signed [ACC_W-1:0]       acc [3];
  logic [ACC_W-FRAC_BITS-1:0]    whole [3];
  rgb_t                          h_rgb_d;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch]   = g_s1_q[ch] + g_s2_q[ch];
      whole[ch] = acc[ch][ACC_W-1:FRAC_BITS];
      if (acc[ch][ACC_W-1]) begin
        h_rgb_d[ch] = '0;
      end else if (|whole[ch][ACC_W-FRAC_BITS-1:COLOR_BITS]) begin
        h_rgb_d[ch] = '1;
      end else begin
        h_rgb_d[ch] = whole[ch][COLOR_BITS-1:0];
      end
    end
  end

  logic h_valid_q;
  rgb_t h_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (en_i) begin
      h_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_rgb_q <= h_rgb_d;
    end
  end

  assign out_valid_o = h_valid_q;
  assign out_rgb_o   = h_rgb_q;

endmodule

`default_nettype wire

### hw/rtl/lut3d_tetrahedral_interp_unit.sv
// Top level of the 3D color LUT with tetrahedral interpolation.
// Depends on lti_pkg, lti_addr, lti_ram and lti_blend.
//
// The input channel (in_valid_i / in_ready_o) carries one word per handshake. A word
// with op_i low writes entry_r/g/b_i into the color table at entry_index_i; indexes
// past the table end are dropped. A word with op_i high is a pixel: coord_x/y/z_i
// (1.16 fixed point, values above 1.0 saturate) select a point in the cube and one
// interpolated color word leaves on the output channel (out_valid_o / out_ready_i).
// Table writes produce no output word. Grid size is written through cfg_we_i and
// cfg_wdata_i while the block is idle; it is clamped to 2..33 internally.
//
// The datapath is a nine-stage pipeline that takes one word per cycle unless a
// finished word is held at the output. The eight corner colors are fetched together
// from eight identical copies of the table, each with its own read port; every table
// write goes to all eight copies at the same pipeline stage as the pixel reads, so
// reads and writes stay in order. When the receiver holds out_ready_i low with a word
// waiting, the whole pipeline freezes and in_ready_o drops; nothing is lost or
// repeated. Reset clears the pipeline valid bits and sets grid size to 33. The table
// is not cleared: every entry must be written before a pixel reads it.
`timescale 1ns / 1ps
`default_nettype none

module lut3d_tetrahedral_interp_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lti_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      op_i,
  input  wire logic [15:0]               entry_index_i,
  input  wire logic [15:0]               entry_r_i,
  input  wire logic [15:0]               entry_g_i,
  input  wire logic [15:0]               entry_b_i,
  input  wire logic [16:0]               coord_x_i,
  input  wire logic [16:0]               coord_y_i,
  input  wire logic [16:0]               coord_z_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [15:0]                    out_r_o,
  output logic [15:0]                    out_g_o,
  output logic [15:0]                    out_b_o
);
  import lti_pkg::*;

  // Grid size register.
  logic [CFG_W-1:0] grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      grid_q <= cfg_wdata_i;
    end
  end

  // The pipeline advances as one unit unless a finished word is being held.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  req_t req;
  always_comb begin
    req.op       = op_i;
    req.idx      = entry_index_i;
    req.color[0] = color_t'(entry_r_i);
    req.color[1] = color_t'(entry_g_i);
    req.color[2] = color_t'(entry_b_i);
    req.cx       = coord_x_i;
    req.cy       = coord_y_i;
    req.cz       = coord_z_i;
  end

  side_t side;
  addr_t corner_addr [NCORN];
  logic  tbl_we;
  rgb_t  tbl_wdata;

  lti_addr u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .grid_i     (grid_q),
    .in_valid_i (in_valid_i),
    .req_i      (req),
    .side_o     (side),
    .addr_o     (corner_addr),
    .we_o       (tbl_we),
    .wdata_o    (tbl_wdata)
  );

  logic ram_we;
  rgb_t corner [NCORN];
  assign ram_we = en && tbl_we;

  for (genvar k = 0; k < NCORN; k++) begin : g_copy
    lti_ram #(
      .DEPTH (CELLS),
      .WIDTH ($bits(rgb_t)),
      .AW    (AW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .re_i    (en),
      .addr_i  (corner_addr[k]),
      .wdata_i (tbl_wdata),
      .rdata_o (corner[k])
    );
  end

  rgb_t out_rgb;

  lti_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .side_i      (side),
    .corner_i    (corner),
    .out_valid_o (out_valid_o),
    .out_rgb_o   (out_rgb)
  );

  assign out_r_o = out_rgb[0];
  assign out_g_o = out_rgb[1];
  assign out_b_o = out_rgb[2];

  // A pixel accepted while out_ready_i stays high afterwards shows up on out_valid_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o)
    else $error("pixel result missing after unstalled latency");

  // The input side only stalls behind a held output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held output word");

  // Table writes happen only while the pipeline moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> en)
    else $error("table written during a stall");

endmodule

`default_nettype wire

### bench/lti_scoreboard.sv
// Scoreboard for the 3D LUT tetrahedral interpolator: mirrors the color table and grid size,
// predicts each pixel word on input acceptance and compares output words in order.
// Depends on lti_pkg for the color and tetrahedron types.
`timescale 1ns / 1ps

module lti_scoreboard (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lti_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic                      op_i,
  input  wire logic [15:0]               entry_index_i,
  input  wire logic [15:0]               entry_r_i,
  input  wire logic [15:0]               entry_g_i,
  input  wire logic [15:0]               entry_b_i,
  input  wire logic [16:0]               coord_x_i,
  input  wire logic [16:0]               coord_y_i,
  input  wire logic [16:0]               coord_z_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic [15:0]               out_r_i,
  input  wire logic [15:0]               out_g_i,
  input  wire logic [15:0]               out_b_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import lti_pkg::*;

  // Corner pairs (plus, minus) for the x, y and z weights of each tetrahedron.
  localparam int unsigned CORNER_PAIRS [6][6] = '{
    '{4, 0, 6, 4, 7, 6}, '{4, 0, 7, 5, 5, 4}, '{5, 1, 7, 5, 1, 0},
    '{6, 2, 2, 0, 7, 6}, '{7, 3, 2, 0, 3, 2}, '{7, 3, 3, 1, 1, 0}
  };

  rgb_t             color_mem [CELLS];
  logic [CFG_W-1:0] grid_cfg;
  rgb_t             pixel_q [$];

  function automatic tetra_e pick_tetra(input int unsigned fx, fy, fz);
    if (fx >= fy && fy >= fz) return TET_XYZ;
    if (fx >= fz && fz >= fy) return TET_XZY;
    if (fz >= fx && fx >= fy) return TET_ZXY;
    if (fy >= fx && fx >= fz) return TET_YXZ;
    if (fy >= fz && fz >= fx) return TET_YZX;
    return TET_ZYX;
  endfunction

  function automatic rgb_t interp_pixel(input logic [16:0] cx, cy, cz);
    int unsigned n, s, xi, yi, zi;
    int unsigned lo [3];
    int unsigned hi [3];
    int unsigned fr [3];
    int unsigned adr [8];
    logic [16:0] crd [3];
    tetra_e      tet;
    longint      acc, diff;
    rgb_t        res;
    n = grid_cfg < 2 ? 2 : (grid_cfg > GRID_MAX ? GRID_MAX : grid_cfg);
    crd[0] = cx;
    crd[1] = cy;
    crd[2] = cz;
    for (int k = 0; k < 3; k++) begin
      s = (crd[k] > ONE_FX ? ONE_FX : crd[k]) * (n - 1);
      lo[k] = s >> FRAC_BITS;
      fr[k] = s & 32'hFFFF;
      hi[k] = (lo[k] + 1 < n) ? lo[k] + 1 : n - 1;
    end
    for (int k = 0; k < 8; k++) begin
      xi = k[2] ? hi[0] : lo[0];
      yi = k[1] ? hi[1] : lo[1];
      zi = k[0] ? hi[2] : lo[2];
      adr[k] = (xi * n + yi) * n + zi;
    end
    tet = pick_tetra(fr[0], fr[1], fr[2]);
    for (int ch = 0; ch < 3; ch++) begin
      acc = longint'(color_mem[adr[0]][ch]) * 65536;
      for (int k = 0; k < 3; k++) begin
        diff = longint'(color_mem[adr[CORNER_PAIRS[tet][2*k]]][ch])
             - longint'(color_mem[adr[CORNER_PAIRS[tet][2*k+1]]][ch]);
        acc += diff * fr[k];
      end
      acc += 32768;
      if (acc < 0) res[ch] = '0;
      else if ((acc >>> FRAC_BITS) > 65535) res[ch] = 16'hFFFF;
      else res[ch] = 16'(acc >>> FRAC_BITS);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      grid_cfg = GRID_RESET;
      pixel_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) grid_cfg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (op_i) pixel_q.push_back(interp_pixel(coord_x_i, coord_y_i, coord_z_i));
        else if (entry_index_i < CELLS) color_mem[entry_index_i] = {entry_b_i, entry_g_i, entry_r_i};
      end
      if (out_valid_i && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = pixel_q.pop_front();
          if (out_r_i !== want[0]) report_mismatch("out_r", out_r_i, want[0]);
          if (out_g_i !== want[1]) report_mismatch("out_g", out_g_i, want[1]);
          if (out_b_i !== want[2]) report_mismatch("out_b", out_b_i, want[2]);
        end
      end
      pending_o = pixel_q.size();
    end
  end

endmodule

### bench/lut3d_tetrahedral_interp_unit_tb.sv
// Testbench top for the 3D LUT tetrahedral interpolator: clock, reset, table loads, pixel
// stimulus with random idling on both channels, a watchdog and the verdict.
// Depends on lti_pkg, the block and the lti_scoreboard checker.
`timescale 1ns / 1ps

module lut3d_tetrahedral_interp_unit_tb;
  import lti_pkg::*;

  // Cycles without any accepted word before the run is declared hung. It is set well
  // above the long receiver hold-off and the longest idle gap.
  localparam int HANG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = 1'b0;
  logic [15:0] entry_index = '0;
  logic [15:0] entry_r = '0;
  logic [15:0] entry_g = '0;
  logic [15:0] entry_b = '0;
  logic [16:0] coord_x = '0;
  logic [16:0] coord_y = '0;
  logic [16:0] coord_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_r, out_g, out_b;
  int          fail_count, pending;

  // Table entries that have been loaded so far; a pixel only ever touches these.
  bit          loaded [CELLS];
  int unsigned grid_n = GRID_MAX;
  bit          hold_req = 1'b0;
  bit          no_idle = 1'b0;
  int          hang_count = 0;

  lut3d_tetrahedral_interp_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .op_i(op), .entry_index_i(entry_index),
    .entry_r_i(entry_r), .entry_g_i(entry_g), .entry_b_i(entry_b),
    .coord_x_i(coord_x), .coord_y_i(coord_y), .coord_z_i(coord_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_r_o(out_r), .out_g_o(out_g), .out_b_o(out_b)
  );

  lti_scoreboard checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .op_i(op), .entry_index_i(entry_index),
    .entry_r_i(entry_r), .entry_g_i(entry_g), .entry_b_i(entry_b),
    .coord_x_i(coord_x), .coord_y_i(coord_y), .coord_z_i(coord_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_r_i(out_r), .out_g_i(out_g), .out_b_i(out_b),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Most gaps are zero or short; a few are long enough to drain the pipeline.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (no_idle || pick < 13) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Offers one word and returns at the edge where it is accepted. Valid stays high
  // when the next word follows without a gap, so it is never dropped and raised
  // again within one time step.
  task automatic send_word(input logic w_op, input logic [15:0] idx, input rgb_t col,
                           input logic [16:0] cx, cy, cz);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    op          <= w_op;
    entry_index <= idx;
    entry_r     <= col[0];
    entry_g     <= col[1];
    entry_b     <= col[2];
    coord_x     <= cx;
    coord_y     <= cy;
    coord_z     <= cz;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic write_entry(input int unsigned idx, input rgb_t col);
    send_word(1'b0, idx[15:0], col, 17'($urandom), 17'($urandom), 17'($urandom));
    if (idx < CELLS) loaded[idx] = 1'b1;
  endtask

  task automatic send_pixel(input logic [16:0] cx, cy, cz);
    send_word(1'b1, 16'($urandom), rgb_t'({$urandom, $urandom}), cx, cy, cz);
  endtask

  // Grid size may only change with the pipeline empty. Table writes produce no
  // output word, so after the last expected pixel the pipeline is given its full
  // depth to retire any trailing writes.
  task automatic set_grid(input logic [5:0] value);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    grid_n = value < 2 ? 2 : (value > GRID_MAX ? GRID_MAX : value);
  endtask

  // Every entry of the active grid must be written before pixels may read it.
  task automatic load_grid();
    for (int unsigned i = 0; i < grid_n * grid_n * grid_n; i++)
      if (!loaded[i]) write_entry(i, rgb_t'({$urandom, $urandom}));
  endtask

  function automatic logic [16:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONE_FX;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Directed part, smallest grid: extreme corner colors, two writes past the table end,
  // pixels at cube corners, above one, on ties and in all six tetrahedra, a corner rewrite.
  task automatic directed_items();
    for (int k = 0; k < 8; k++)
      write_entry(k, rgb_t'({k[0] ? 16'hFFFF : 16'h0000, k[1] ? 16'hFFFF : 16'h0000,
                             k[2] ? 16'hFFFF : 16'h0000}));
    write_entry(CELLS, rgb_t'('1));
    write_entry(16'hFFFF, rgb_t'('0));
    send_pixel(17'd0, 17'd0, 17'd0);
    send_pixel(ONE_FX, ONE_FX, ONE_FX);
    send_pixel(17'h1FFFF, 17'd70000, 17'd65537);
    send_pixel(17'd32768, 17'd32768, 17'd32768);
    send_pixel(17'd30000, 17'd30000, 17'd10000);
    send_pixel(17'd10000, 17'd30000, 17'd30000);
    send_pixel(17'd40000, 17'd20000, 17'd10000);
    send_pixel(17'd40000, 17'd10000, 17'd20000);
    send_pixel(17'd20000, 17'd10000, 17'd40000);
    send_pixel(17'd20000, 17'd40000, 17'd10000);
    send_pixel(17'd10000, 17'd40000, 17'd20000);
    send_pixel(17'd10000, 17'd20000, 17'd40000);
    write_entry(7, rgb_t'({16'h1234, 16'hFFFF, 16'h0000}));
    send_pixel(17'd65535, 17'd65535, 17'd65535);
  endtask

  // Mostly pixels on the loaded grid, with rewrites of live entries and writes past
  // the table end mixed in.
  task automatic random_items(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) send_pixel(rand_coord(), rand_coord(), rand_coord());
      else if (pick < 9)
        write_entry($urandom_range(0, grid_n * grid_n * grid_n - 1), rgb_t'({$urandom, $urandom}));
      else write_entry($urandom_range(CELLS, 65535), rgb_t'({$urandom, $urandom}));
    end
  endtask

  // Receiver: runs of ready of random length and gaps from the same mix as the
  // sender. Once asked, it cuts the run short and holds ready low so the block
  // backs up.
  initial begin
    int run;
    int gap;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      out_ready <= 1'b1;
      for (int i = 0; i < run && !hold_req; i++) @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (500) @(posedge clk_i);
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) hang_count <= 0;
    else hang_count <= hang_count + 1;
    if (hang_count >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Grid sizes stay small so the full table of each stays short to load; sizes
  // below two exercise the lower clamp.
  initial begin
    logic [5:0] grid_values [10];
    grid_values = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd2, 6'd4, 6'd3, 6'd5};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 10; p++) begin
      set_grid(grid_values[p]);
      no_idle = (p == 4);
      load_grid();
      if (p == 0) directed_items();
      if (p == 2) hold_req = 1'b1;
      random_items(60);
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### lut3d_tetrahedral_interp_unit.f
hw/rtl/lti_pkg.sv
hw/rtl/lti_ram.sv
hw/rtl/lti_addr.sv
hw/rtl/lti_blend.sv
hw/rtl/lut3d_tetrahedral_interp_unit.sv
bench/lti_scoreboard.sv
bench/lut3d_tetrahedral_interp_unit_tb.sv
